### rtl/pfa_pkg.sv
package pfa_pkg;

    localparam int WORD_W  = 32;
    localparam int WORD_AW = 5;
    localparam int PAGE_W  = 16;
    localparam int LIM_W   = 17;
    localparam int ROW_W   = LIM_W - WORD_AW;
    localparam int CNT_W   = 17;
    localparam int CMD_W   = 3;
    localparam int STS_W   = 2;

    localparam logic [CNT_W-1:0] CNT_MAX    = 17'h1FFFF;
    localparam logic [CNT_W-1:0] RESET_FREE = 17'h10000;
    localparam logic [LIM_W-1:0] RESET_ACTIVE = 17'h10000;

    localparam logic [CMD_W-1:0] CMD_REQUEST   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOCK      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESERVE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_UNRESERVE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

    localparam logic [STS_W-1:0] STS_OK           = 2'd0;
    localparam logic [STS_W-1:0] STS_ALREADY      = 2'd1;
    localparam logic [STS_W-1:0] STS_NO_FREE      = 2'd2;
    localparam logic [STS_W-1:0] STS_OUT_OF_RANGE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_SCAN,
        ST_CLEAR,
        ST_REPLY
    } t_state;

    typedef struct packed {
        logic               found;
        logic [WORD_AW-1:0] bit_idx;
    } t_scan_res;

endpackage

### rtl/page_frame_allocator.sv
// Page frame allocator over a one-bit-per-page in-use map held in a RAM of
// 32-page words (NUM_PAGES/32 rows). Commands use a valid/stall request
// channel and give one result each on a valid/stall result channel; a new
// request is taken while the previous result waits in the output register.
// Lock, free, reserve and unreserve do a RAM read, then a modify-write. A
// request walks map words from the search hint with the first-free finder,
// at most active_pages/32 (rounded up) words; out-of-range and unknown
// commands go straight to the result. Clear sweeps the whole RAM, one row
// a cycle. After reset the same sweep runs first, without a result, and
// with requests stalled; active_pages may be written at any time the block
// is idle and takes effect on the next request.
module page_frame_allocator #(
    parameter int NUM_PAGES = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pfa_pkg::LIM_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [pfa_pkg::CMD_W-1:0]   i_command,
    input  logic [pfa_pkg::PAGE_W-1:0]  i_page_number,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [pfa_pkg::PAGE_W-1:0]  o_granted_page,
    output logic [pfa_pkg::STS_W-1:0]   o_status,
    output logic [pfa_pkg::CNT_W-1:0]   o_free_count,
    output logic [pfa_pkg::CNT_W-1:0]   o_used_count,
    output logic [pfa_pkg::CNT_W-1:0]   o_reserved_count
);
    import pfa_pkg::*;

    localparam int ROWS    = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_CW  = (ROW_AW > ROW_W) ? ROW_AW : ROW_W;
    localparam int LIM_CAP = (NUM_PAGES > 131071) ? 131071 : NUM_PAGES;

    localparam logic [LIM_W-1:0]  LIMIT_CAP = LIM_W'(LIM_CAP);
    localparam logic [ROW_CW-1:0] LAST_ROW  = ROW_CW'(ROWS - 1);

    t_state             r_state, n_state;
    logic [LIM_W-1:0]   r_active;
    logic [LIM_W-1:0]   r_hint, n_hint;
    logic [CNT_W-1:0]   r_free, n_free;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [CNT_W-1:0]   r_reserved, n_reserved;
    logic [ROW_CW-1:0]  r_row, n_row;
    logic               r_first, n_first;
    logic               r_clr_reply, n_clr_reply;
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [LIM_W-1:0]   r_page, n_page;
    logic [PAGE_W-1:0]  r_res_page, n_res_page;
    logic [STS_W-1:0]   r_res_status, n_res_status;

    logic               r_o_valid, n_o_valid;
    logic [PAGE_W-1:0]  r_o_page, n_o_page;
    logic [STS_W-1:0]   r_o_status, n_o_status;
    logic [CNT_W-1:0]   r_o_free, n_o_free;
    logic [CNT_W-1:0]   r_o_used, n_o_used;
    logic [CNT_W-1:0]   r_o_reserved, n_o_reserved;

    logic [LIM_W-1:0]   lim;
    logic [ROW_W-1:0]   last_scan_row;
    logic               out_free;
    logic               in_ready;
    logic               acc;
    logic [LIM_W-1:0]   page_ext;
    logic               in_range;
    logic               hint_ok;
    logic               scan_last;
    logic               take_cmd;
    logic               cur_bit;
    logic [WORD_W-1:0]  bit_mask;
    logic [WORD_W-1:0]  found_mask;
    logic [LIM_W-1:0]   found_page;

    logic               rd_en;
    logic [ROW_AW-1:0]  rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic               wr_en;
    logic [ROW_AW-1:0]  wr_addr;
    logic [WORD_W-1:0]  wr_data;
    t_scan_res          scan_res;

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
        return (v == '0) ? v : v - CNT_W'(1);
    endfunction

    pfa_map #(
        .ROWS   (ROWS),
        .ROW_AW (ROW_AW)
    ) u_map (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    pfa_scan u_scan (
        .i_word      (rd_data),
        .i_start_bit (r_first ? r_hint[WORD_AW-1:0] : WORD_AW'(0)),
        .i_row       (r_row[ROW_W-1:0]),
        .i_limit     (lim),
        .o_res       (scan_res)
    );

    assign lim           = (r_active < LIMIT_CAP) ? r_active : LIMIT_CAP;
    assign last_scan_row = ROW_W'((lim - LIM_W'(1)) >> WORD_AW);
    assign out_free      = !r_o_valid || !i_out_stall;
    assign in_ready      = (r_state == ST_IDLE) || ((r_state == ST_REPLY) && out_free);
    assign o_in_stall    = !in_ready;
    assign acc           = i_in_valid && in_ready;
    assign page_ext      = {1'b0, i_page_number};
    assign in_range      = page_ext < lim;
    assign hint_ok       = r_hint < lim;
    assign scan_last     = r_row == ROW_CW'(last_scan_row);
    assign take_cmd      = (r_cmd == CMD_LOCK) || (r_cmd == CMD_RESERVE);
    assign cur_bit       = rd_data[r_page[WORD_AW-1:0]];
    assign bit_mask      = WORD_W'(1) << r_page[WORD_AW-1:0];
    assign found_mask    = WORD_W'(1) << scan_res.bit_idx;
    assign found_page    = {r_row[ROW_W-1:0], scan_res.bit_idx};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE, ST_REPLY: begin
                if (r_state == ST_REPLY && !out_free) begin
                    n_state = ST_REPLY;
                end else if (acc) begin
                    case (i_command)
                        CMD_REQUEST:   n_state = hint_ok ? ST_SCAN : ST_REPLY;
                        CMD_LOCK,
                        CMD_FREE,
                        CMD_RESERVE,
                        CMD_UNRESERVE: n_state = in_range ? ST_TEST : ST_REPLY;
                        CMD_CLEAR:     n_state = ST_CLEAR;
                        default:       n_state = ST_REPLY;
                    endcase
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_TEST: n_state = ST_REPLY;
            ST_SCAN: begin
                if (scan_res.found || scan_last) begin
                    n_state = ST_REPLY;
                end
            end
            ST_CLEAR: begin
                if (r_row == LAST_ROW) begin
                    n_state = r_clr_reply ? ST_REPLY : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and map access
    always_comb begin
        n_hint       = r_hint;
        n_free       = r_free;
        n_used       = r_used;
        n_reserved   = r_reserved;
        n_row        = r_row;
        n_first      = r_first;
        n_clr_reply  = r_clr_reply;
        n_cmd        = r_cmd;
        n_page       = r_page;
        n_res_page   = r_res_page;
        n_res_status = r_res_status;
        n_o_valid    = r_o_valid;
        n_o_page     = r_o_page;
        n_o_status   = r_o_status;
        n_o_free     = r_o_free;
        n_o_used     = r_o_used;
        n_o_reserved = r_o_reserved;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = ROW_AW'(r_row);
        wr_data      = '0;

        if (r_state == ST_REPLY && out_free) begin
            n_o_valid    = 1'b1;
            n_o_page     = r_res_page;
            n_o_status   = r_res_status;
            n_o_free     = r_free;
            n_o_used     = r_used;
            n_o_reserved = r_reserved;
        end else if (!i_out_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE, ST_REPLY: begin
                if (acc) begin
                    n_cmd        = i_command;
                    n_page       = page_ext;
                    n_res_page   = '0;
                    n_res_status = STS_OK;
                    case (i_command)
                        CMD_REQUEST: begin
                            if (hint_ok) begin
                                rd_en   = 1'b1;
                                rd_addr = ROW_AW'(r_hint[LIM_W-1:WORD_AW]);
                                n_row   = ROW_CW'(r_hint[LIM_W-1:WORD_AW]);
                                n_first = 1'b1;
                            end else begin
                                n_res_status = STS_NO_FREE;
                            end
                        end
                        CMD_LOCK, CMD_FREE, CMD_RESERVE, CMD_UNRESERVE: begin
                            if (in_range) begin
                                rd_en   = 1'b1;
                                rd_addr = ROW_AW'(page_ext[LIM_W-1:WORD_AW]);
                            end else begin
                                n_res_status = STS_OUT_OF_RANGE;
                            end
                        end
                        CMD_CLEAR: begin
                            n_row       = '0;
                            n_clr_reply = 1'b1;
                        end
                        default: n_res_status = STS_ALREADY;
                    endcase
                end
            end
            ST_TEST: begin
                wr_addr = ROW_AW'(r_page[LIM_W-1:WORD_AW]);
                if (take_cmd) begin
                    if (cur_bit) begin
                        n_res_status = STS_ALREADY;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = rd_data | bit_mask;
                        n_free  = dec_sat(r_free);
                        if (r_cmd == CMD_RESERVE) begin
                            n_reserved = inc_sat(r_reserved);
                        end else begin
                            n_used = inc_sat(r_used);
                        end
                    end
                end else begin
                    if (!cur_bit) begin
                        n_res_status = STS_ALREADY;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = rd_data & ~bit_mask;
                        n_free  = inc_sat(r_free);
                        if (r_cmd == CMD_UNRESERVE) begin
                            n_reserved = dec_sat(r_reserved);
                        end else begin
                            n_used = dec_sat(r_used);
                        end
                        if (r_page < r_hint) begin
                            n_hint = r_page;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (scan_res.found) begin
                    wr_en      = 1'b1;
                    wr_data    = rd_data | found_mask;
                    n_free     = dec_sat(r_free);
                    n_used     = inc_sat(r_used);
                    n_hint     = found_page;
                    n_res_page = found_page[PAGE_W-1:0];
                end else if (scan_last) begin
                    if (hint_ok) begin
                        n_hint = lim;
                    end
                    n_res_status = STS_NO_FREE;
                end else begin
                    n_row   = r_row + ROW_CW'(1);
                    n_first = 1'b0;
                    rd_en   = 1'b1;
                    rd_addr = ROW_AW'(r_row + ROW_CW'(1));
                end
            end
            ST_CLEAR: begin
                wr_en = 1'b1;
                n_row = r_row + ROW_CW'(1);
                if (r_row == LAST_ROW && r_clr_reply) begin
                    n_hint       = '0;
                    n_free       = lim;
                    n_used       = '0;
                    n_reserved   = '0;
                    n_res_status = STS_OK;
                    n_res_page   = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_active    <= RESET_ACTIVE;
            r_hint      <= '0;
            r_free      <= RESET_FREE;
            r_used      <= '0;
            r_reserved  <= '0;
            r_row       <= '0;
            r_first     <= 1'b0;
            r_clr_reply <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            r_hint      <= n_hint;
            r_free      <= n_free;
            r_used      <= n_used;
            r_reserved  <= n_reserved;
            r_row       <= n_row;
            r_first     <= n_first;
            r_clr_reply <= n_clr_reply;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_page       <= n_page;
        r_res_page   <= n_res_page;
        r_res_status <= n_res_status;
        r_o_page     <= n_o_page;
        r_o_status   <= n_o_status;
        r_o_free     <= n_o_free;
        r_o_used     <= n_o_used;
        r_o_reserved <= n_o_reserved;
    end

    assign o_out_valid      = r_o_valid;
    assign o_granted_page   = r_o_page;
    assign o_status         = r_o_status;
    assign o_free_count     = r_o_free;
    assign o_used_count     = r_o_used;
    assign o_reserved_count = r_o_reserved;

    a_scan_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_row <= ROW_CW'(last_scan_row)))
        else $error("scan row past active limit");

    a_clear_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && r_clr_reply && r_row == LAST_ROW)
        |=> (r_used == '0 && r_reserved == '0 && r_free == $past(lim) && r_hint == '0))
        else $error("clear left counts or hint");

    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPLY && r_cmd == CMD_REQUEST && r_res_status == STS_OK)
        |-> ({1'b0, r_res_page} < lim && r_hint == {1'b0, r_res_page}))
        else $error("granted page outside limit or hint not moved");

    a_no_free_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STS_NO_FREE) |-> (o_granted_page == '0))
        else $error("failed request carries a page");

endmodule

### rtl/pfa_map.sv
module pfa_map #(
    parameter int ROWS    = 2048,
    parameter int ROW_AW  = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [ROW_AW-1:0]           i_rd_addr,
    output logic [pfa_pkg::WORD_W-1:0]  o_rd_data,
    input  logic                        i_wr_en,
    input  logic [ROW_AW-1:0]           i_wr_addr,
    input  logic [pfa_pkg::WORD_W-1:0]  i_wr_data
);
    import pfa_pkg::*;

    logic [WORD_W-1:0] r_mem [ROWS];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/pfa_scan.sv
module pfa_scan (
    input  logic [pfa_pkg::WORD_W-1:0]  i_word,
    input  logic [pfa_pkg::WORD_AW-1:0] i_start_bit,
    input  logic [pfa_pkg::ROW_W-1:0]   i_row,
    input  logic [pfa_pkg::LIM_W-1:0]   i_limit,
    output pfa_pkg::t_scan_res          o_res
);
    import pfa_pkg::*;

    logic [WORD_W-1:0]  start_mask;
    logic [WORD_W-1:0]  end_mask;
    logic [WORD_W-1:0]  cand;
    logic [WORD_W-1:0]  lowest;
    logic [WORD_AW-1:0] idx;

    always_comb begin
        start_mask = {WORD_W{1'b1}} << i_start_bit;
        if (i_row == i_limit[LIM_W-1:WORD_AW]) begin
            end_mask = ~({WORD_W{1'b1}} << i_limit[WORD_AW-1:0]);
        end else begin
            end_mask = {WORD_W{1'b1}};
        end
        cand   = ~i_word & start_mask & end_mask;
        lowest = cand & (~cand + WORD_W'(1));
        idx    = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (lowest[i]) begin
                idx = idx | WORD_AW'(i);
            end
        end
        o_res.found   = |cand;
        o_res.bit_idx = idx;
    end

endmodule
